>>> src/sync_frame_deframer_crc8_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync frame deframer
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_DEFRAMER_CRC8_MACROS_SVH
`define SYNC_FRAME_DEFRAMER_CRC8_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfdcrc8 check failed");

// next-cycle implication
`define SFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfdcrc8 check failed");

`endif

>>> src/sfdcrc8_pkg.sv
// ----------------------------------------------------------------------------
// sfdcrc8_pkg
// Types and constants shared by the deframer controller and datapath.
// ----------------------------------------------------------------------------
package sfdcrc8_pkg;

  localparam int unsigned FifoDepthDef   = 256;
  localparam int unsigned MaxFrameLenDef = 63;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [7:0] SyncByteRst = 8'd200;
  localparam logic [7:0] CrcPolyRst  = 8'd213;

  // frame shape
  localparam int unsigned MinHeld    = 4;
  localparam int unsigned MinLen     = 2;
  localparam int unsigned ExtraBytes = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_BYTE = 1'b0,
    CFG_CRC_POLY  = 1'b1
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic       push_en;
    logic       rd_en;
    logic [7:0] rd_off;
    logic       drop_en;
    logic [7:0] drop_n;
    logic       crc_clr;
    logic       crc_en;
    logic       first_ld;
    logic       out_ld;
    logic       out_found;
    logic       out_two;
    logic       out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [7:0] rdata;
    logic       fill_ge_min;
    logic       fill_ge_total;
    logic       len_ok;
    logic       sync_match;
    logic       crc_ok;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> src/sfdcrc8_dp.sv
// ----------------------------------------------------------------------------
// sfdcrc8_dp
// Byte store, head/fill pointers, CRC-8 register, config registers and the
// output register of the deframer.
// ----------------------------------------------------------------------------
module sfdcrc8_dp import sfdcrc8_pkg::*; #(
  parameter int unsigned FIFO_DEPTH    = FifoDepthDef,
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic [7:0]         data_byte_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [7:0]         first_byte_o,
  output logic [7:0]         second_byte_o,
  output logic [1:0]         bytes_valid_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = ((AW > 8) ? AW : 8) + 1;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]    mem_q [FIFO_DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    crc_q, crc_d;
  logic [7:0]    sync_q, poly_q;
  logic [7:0]    first_q;
  logic          out_valid_q;
  logic          found_q, last_q;
  logic [7:0]    first_out_q, second_out_q;
  logic [1:0]    bv_q;

  logic [SW-1:0] rd_sum, wr_sum, dr_sum;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic          out_take;

  // offsets stay below the depth, so one conditional subtract wraps them
  always_comb begin
    rd_sum  = SW'(head_q) + SW'(cmd_i.rd_off);
    wr_sum  = SW'(head_q) + SW'(fill_q);
    dr_sum  = SW'(head_q) + SW'(cmd_i.drop_n);
    rd_addr = (rd_sum >= SW'(FIFO_DEPTH)) ? AW'(rd_sum - SW'(FIFO_DEPTH)) : AW'(rd_sum);
    wr_addr = (wr_sum >= SW'(FIFO_DEPTH)) ? AW'(wr_sum - SW'(FIFO_DEPTH)) : AW'(wr_sum);
    wr_en   = cmd_i.push_en && (SW'(fill_q) < SW'(FIFO_DEPTH));
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (wr_en) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.drop_en) begin
      head_d = (dr_sum >= SW'(FIFO_DEPTH)) ? AW'(dr_sum - SW'(FIFO_DEPTH)) : AW'(dr_sum);
      fill_d = fill_q - FW'(cmd_i.drop_n);
    end
    crc_d = crc_q;
    if (cmd_i.crc_clr) begin
      crc_d = '0;
    end else if (cmd_i.crc_en) begin
      crc_d = crc8_step(crc_q, rdata_q, poly_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= data_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      sync_q <= SyncByteRst;
      poly_q <= CrcPolyRst;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SYNC_BYTE: sync_q <= cfg_data_i;
          CFG_CRC_POLY:  poly_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (cmd_i.first_ld) begin
      first_q <= rdata_q;
    end
  end

  // output register
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      found_q      <= cmd_i.out_found;
      last_q       <= cmd_i.out_last;
      first_out_q  <= cmd_i.out_found ? first_q : 8'd0;
      second_out_q <= (cmd_i.out_found && cmd_i.out_two) ? rdata_q : 8'd0;
      bv_q         <= !cmd_i.out_found ? 2'd0 : (cmd_i.out_two ? 2'd2 : 2'd1);
    end
  end

  always_comb begin
    stat_o.rdata         = rdata_q;
    stat_o.fill_ge_min   = SW'(fill_q) >= SW'(MinHeld);
    stat_o.fill_ge_total = SW'(fill_q) >= (SW'(rdata_q) + SW'(ExtraBytes));
    stat_o.len_ok        = (rdata_q >= 8'(MinLen)) && (rdata_q <= 8'(MAX_FRAME_LEN));
    stat_o.sync_match    = rdata_q == sync_q;
    stat_o.crc_ok        = rdata_q == crc_q;
    stat_o.out_free      = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign first_byte_o  = first_out_q;
  assign second_byte_o = second_out_q;
  assign bytes_valid_o = bv_q;
  assign last_o        = last_q;

endmodule

>>> src/sfdcrc8_ctrl.sv
// ----------------------------------------------------------------------------
// sfdcrc8_ctrl
// Sequencer for push and pop: header check, CRC walk, pairwise emission.
// ----------------------------------------------------------------------------
module sfdcrc8_ctrl import sfdcrc8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     action_i,
  output logic     in_stall_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_HDR0,
    ST_HDR1,
    ST_CRC,
    ST_EMRD,
    ST_EMFIRST,
    ST_EMLD,
    ST_NOTF
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] em_q, em_d;

  logic [8:0] total;
  logic       at_crc_byte;
  logic       em_two;
  logic       em_last;

  always_comb begin
    total       = {1'b0, len_q} + 9'(ExtraBytes);
    at_crc_byte = {1'b0, pos_q} == ({1'b0, len_q} + 9'd1);
    em_two      = ({1'b0, em_q} + 9'd1) < total;
    em_last     = ({1'b0, em_q} + 9'd2) >= total;
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    pos_d   = pos_q;
    em_d    = em_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i) begin
            state_d = ST_CHK;
          end else begin
            cmd_o.push_en = 1'b1;
          end
        end
      end
      ST_CHK: begin
        if (!stat_i.fill_ge_min) begin
          state_d = ST_NOTF;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_off = 8'd0;
          state_d      = ST_HDR0;
        end
      end
      ST_HDR0: begin
        if (!stat_i.sync_match) begin
          cmd_o.drop_en = 1'b1;
          cmd_o.drop_n  = 8'd1;
          state_d       = ST_CHK;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_off = 8'd1;
          state_d      = ST_HDR1;
        end
      end
      ST_HDR1: begin
        if (!stat_i.len_ok) begin
          // bad length: only the sync byte goes
          cmd_o.drop_en = 1'b1;
          cmd_o.drop_n  = 8'd1;
          state_d       = ST_CHK;
        end else if (!stat_i.fill_ge_total) begin
          state_d = ST_NOTF;
        end else begin
          len_d         = stat_i.rdata;
          cmd_o.crc_clr = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_off  = 8'(ExtraBytes);
          pos_d         = 8'(ExtraBytes);
          state_d       = ST_CRC;
        end
      end
      ST_CRC: begin
        // rdata holds the byte at offset pos_q
        if (at_crc_byte) begin
          if (stat_i.crc_ok) begin
            em_d    = 8'd0;
            state_d = ST_EMRD;
          end else begin
            cmd_o.drop_en = 1'b1;
            cmd_o.drop_n  = 8'(total);
            state_d       = ST_CHK;
          end
        end else begin
          cmd_o.crc_en = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_off = pos_q + 8'd1;
          pos_d        = pos_q + 8'd1;
        end
      end
      ST_EMRD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_off = em_q;
        state_d      = ST_EMFIRST;
      end
      ST_EMFIRST: begin
        cmd_o.first_ld = 1'b1;
        if (em_two) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_off = em_q + 8'd1;
        end
        state_d = ST_EMLD;
      end
      ST_EMLD: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld    = 1'b1;
          cmd_o.out_found = 1'b1;
          cmd_o.out_two   = em_two;
          cmd_o.out_last  = em_last;
          if (em_last) begin
            cmd_o.drop_en = 1'b1;
            cmd_o.drop_n  = 8'(total);
            state_d       = ST_IDLE;
          end else begin
            em_d    = em_q + 8'd2;
            state_d = ST_EMRD;
          end
        end
      end
      ST_NOTF: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      pos_q   <= '0;
      em_q    <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      em_q    <= em_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

>>> src/sync_frame_deframer_crc8.sv
// ----------------------------------------------------------------------------
// sync_frame_deframer_crc8
// Byte FIFO with sync/length frame recovery and CRC-8 check.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_stall_o): action_i=0 pushes data_byte_i into
// the store, action_i=1 requests the next good frame. Pushes may follow back
// to back while no pop is running; a push into a full store is dropped.
// A pop holds in_stall_o high until its last result has been loaded into the
// output register. Scanning goes through the single read port of the byte
// store: a non-sync head byte is read and discarded, a sync byte with a bad
// length is dropped, a good header starts a CRC walk over the frame, then
// each byte pair is read and emitted; a not-found answer follows when too
// few bytes are held. A push gives no result.
// Output channel (out_valid_o/out_stall_i): one result register; a stalled
// result holds and the sequencer waits before loading the next pair.
// Config channel (cfg_valid_i/cfg_ready_o) is always ready; write it only
// while the block is idle.
// Reset clears head, fill count, output valid and config registers to their
// defaults; no clearing pass runs, the store contents are undefined.
// ----------------------------------------------------------------------------
module sync_frame_deframer_crc8 import sfdcrc8_pkg::*; #(
  parameter int unsigned FIFO_DEPTH    = FifoDepthDef,
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [7:0]         first_byte_o,
  output logic [7:0]         second_byte_o,
  output logic [1:0]         bytes_valid_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfdcrc8_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  sfdcrc8_dp #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .data_byte_i   (data_byte_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .bytes_valid_o (bytes_valid_o),
    .last_o        (last_o)
  );

endmodule

>>> src/sfdcrc8_checker.sv
// ----------------------------------------------------------------------------
// sfdcrc8_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sync_frame_deframer_crc8_macros.svh"

module sfdcrc8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       action_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       found_o,
  input logic [7:0] first_byte_o,
  input logic [7:0] second_byte_o,
  input logic [1:0] bytes_valid_o,
  input logic       last_o
);

  // stalled result holds
  `SFD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(found_o) && $stable(first_byte_o) &&
    $stable(second_byte_o) && $stable(bytes_valid_o) && $stable(last_o))

  // not-found is a single closing item with no data
  `SFD_ASSERT_IMP(a_notfound_shape, out_valid_o && !found_o,
    last_o && bytes_valid_o == 2'd0 && first_byte_o == 8'd0 && second_byte_o == 8'd0)

  // an odd byte only ever closes a frame
  `SFD_ASSERT_IMP(a_odd_is_last, out_valid_o && found_o,
    (bytes_valid_o == 2'd2) || (bytes_valid_o == 2'd1 && last_o && second_byte_o == 8'd0))

  // a pop occupies the input side at least for the next cycle
  `SFD_ASSERT_NXT(a_pop_busy, in_valid_i && !in_stall_o && action_i, in_stall_o)

endmodule

bind sync_frame_deframer_crc8 sfdcrc8_checker u_sfdcrc8_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .found_o       (found_o),
  .first_byte_o  (first_byte_o),
  .second_byte_o (second_byte_o),
  .bytes_valid_o (bytes_valid_o),
  .last_o        (last_o)
);

>>> tb/sv/sfd_tb_pkg.sv
// ----------------------------------------------------------------------------
// sfd_tb_pkg
// Codes and the CRC-8 byte update shared by the deframer stimulus and checker.
// ----------------------------------------------------------------------------
package sfd_tb_pkg;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  // one byte through an MSB-first CRC-8
  function automatic logic [7:0] crc8_next(input logic [7:0] poly, input logic [7:0] crc,
                                           input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> tb/sv/sfd_frame_checker.sv
// ----------------------------------------------------------------------------
// sfd_frame_checker
// Watches the deframer's input, output and register channels, tracks the
// byte FIFO and frame scan on its own, and compares every result transfer
// against the oldest predicted byte pair.
// ----------------------------------------------------------------------------
module sfd_frame_checker import sfdcrc8_pkg::*, sfd_tb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic [7:0]         data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               found_i,
  input  logic [7:0]         first_byte_i,
  input  logic [7:0]         second_byte_i,
  input  logic [1:0]         bytes_valid_i,
  input  logic               last_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       found;
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic [1:0] nbytes;
    logic       last_f;
  } pair_t;

  pair_t      pair_q[$];
  logic [7:0] fifo_mem [FifoDepthDef];
  int         rd_ptr;
  int         held;
  logic [7:0] sync_cur;
  logic [7:0] poly_cur;
  int         errs = 0;

  function automatic logic [7:0] held_byte(input int k);
    return fifo_mem[(rd_ptr + k) % FifoDepthDef];
  endfunction

  function automatic void drop(input int n);
    rd_ptr = (rd_ptr + n) % FifoDepthDef;
    held   = held - n;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errs++;
    end
  endfunction

  // scan the head for the next good frame; queue its pairs or a not-found
  task automatic predict_pop();
    int         flen;
    int         total;
    logic [7:0] crc;
    logic [7:0] frame [MaxFrameLenDef + ExtraBytes];
    pair_t      w;
    while (held >= MinHeld) begin
      if (held_byte(0) != sync_cur) begin
        drop(1);
        continue;
      end
      flen = held_byte(1);
      if (flen < MinLen || flen > MaxFrameLenDef) begin
        drop(1);
        continue;
      end
      total = flen + ExtraBytes;
      if (held < total) break;
      for (int i = 0; i < total; i++) frame[i] = held_byte(i);
      drop(total);
      crc = 8'h00;
      for (int i = ExtraBytes; i < total - 1; i++) crc = crc8_next(poly_cur, crc, frame[i]);
      if (crc == frame[total-1]) begin
        for (int i = 0; i < total; i += 2) begin
          w.found    = 1'b1;
          w.first_b  = frame[i];
          w.second_b = (i + 1 < total) ? frame[i+1] : 8'h00;
          w.nbytes   = (i + 1 < total) ? 2'd2 : 2'd1;
          w.last_f   = (i + 2 >= total);
          pair_q.push_back(w);
        end
        return;
      end
    end
    w        = '0;
    w.last_f = 1'b1;
    pair_q.push_back(w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pair_t want;
    if (!rst_ni) begin
      pair_q.delete();
      rd_ptr      = 0;
      held        = 0;
      sync_cur    = SyncByteRst;
      poly_cur    = CrcPolyRst;
      err_count_o <= errs;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pair_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          errs++;
        end else begin
          want = pair_q.pop_front();
          check_field("found", want.found, found_i);
          check_field("first_byte", want.first_b, first_byte_i);
          check_field("second_byte", want.second_b, second_byte_i);
          check_field("bytes_valid", want.nbytes, bytes_valid_i);
          check_field("last", want.last_f, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_e'(action_i) == ACT_PUSH) begin
          // full store drops the byte
          if (held < FifoDepthDef) begin
            fifo_mem[(rd_ptr + held) % FifoDepthDef] = data_byte_i;
            held++;
          end
        end else begin
          predict_pop();
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SYNC_BYTE: sync_cur = cfg_data_i;
          CFG_CRC_POLY:  poly_cur = cfg_data_i;
          default: ;
        endcase
      end
      err_count_o <= errs;
      pending_o   <= pair_q.size();
    end
  end

endmodule

>>> tb/sv/tb_sync_frame_deframer_crc8.sv
// ----------------------------------------------------------------------------
// tb_sync_frame_deframer_crc8
// Drives pushes of framed and broken byte streams plus frame requests into
// the deframer under several sync/polynomial settings, with random gaps and
// output stalls, a long output hold and a FIFO overflow; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sync_frame_deframer_crc8 import sfdcrc8_pkg::*, sfd_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles  = 20;
  localparam int PhaseItems    = 25;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               action_i      = ACT_PUSH;
  logic [7:0]         data_byte_i   = 8'h00;
  logic               out_stall_i   = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = CFG_SYNC_BYTE;
  logic [7:0]         cfg_data_i    = 8'h00;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               found_o;
  logic [7:0]         first_byte_o;
  logic [7:0]         second_byte_o;
  logic [1:0]         bytes_valid_o;
  logic               last_o;
  logic               cfg_ready_o;

  int         err_count;
  int         pending;
  int         items_sent  = 0;
  int         idle_cycles = 0;
  bit         quiet       = 1'b0;
  int         hold_seq    = 0;
  int         hold_seen   = 0;
  int         hold_left   = 0;
  logic [7:0] cur_sync    = SyncByteRst;
  logic [7:0] cur_poly    = CrcPolyRst;

  always #5 clk_i = ~clk_i;

  sync_frame_deframer_crc8 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .bytes_valid_o (bytes_valid_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sfd_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_i       (found_o),
    .first_byte_i  (first_byte_o),
    .second_byte_i (second_byte_o),
    .bytes_valid_i (bytes_valid_o),
    .last_i        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // result side: long hold on request, else random stalls unless quiet
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 28);
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input action_e act, input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic pop();
    send(ACT_POP, 8'($urandom_range(255)));
  endtask

  // push {sync, len, type, payload, crc}; keep cuts the frame short
  task automatic push_frame(input int flen, input bit corrupt, input int keep = 255);
    logic [7:0] crc;
    logic [7:0] b;
    int         total;
    total = flen + ExtraBytes;
    crc   = 8'h00;
    for (int i = 0; i < total && i < keep; i++) begin
      if (i == 0) begin
        b = cur_sync;
      end else if (i == 1) begin
        b = 8'(flen);
      end else if (i == total - 1) begin
        b = corrupt ? (crc ^ (8'h01 << $urandom_range(7))) : crc;
      end else begin
        b   = 8'($urandom_range(255));
        crc = crc8_next(cur_poly, crc, b);
      end
      send(ACT_PUSH, b);
    end
  endtask

  // stop offering and wait until every queued result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] p);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SYNC_BYTE;
    cfg_data_i  <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_CRC_POLY;
    cfg_data_i  <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_sync = s;
    cur_poly = p;
  endtask

  task automatic directed();
    pop();                       // empty store
    push_frame(2, 1'b0);         // shortest frame, even byte count
    pop();
    push_frame(3, 1'b0);         // odd byte count
    pop();
    send(ACT_PUSH, 8'h00);       // junk ahead of sync
    send(ACT_PUSH, 8'hFF);
    send(ACT_PUSH, cur_sync);    // length too short
    send(ACT_PUSH, 8'(MinLen - 1));
    send(ACT_PUSH, cur_sync);    // length too long
    send(ACT_PUSH, 8'(MaxFrameLenDef + 1));
    push_frame(2, 1'b1);         // CRC mismatch
    pop();
    push_frame(9, 1'b0, 4);      // header plus two bytes, frame incomplete
    pop();
  endtask

  task automatic random_burst();
    int pick;
    int flen;
    pick = $urandom_range(99);
    flen = ($urandom_range(7) == 0) ? $urandom_range(MinLen, MaxFrameLenDef)
                                    : $urandom_range(MinLen, 10);
    if (pick < 45) begin
      push_frame(flen, 1'b0);
      if ($urandom_range(1)) pop();
    end else if (pick < 57) begin
      repeat ($urandom_range(1, 5)) send(ACT_PUSH, 8'($urandom_range(255)));
    end else if (pick < 67) begin
      send(ACT_PUSH, cur_sync);
      send(ACT_PUSH, $urandom_range(1) ? 8'($urandom_range(MinLen - 1))
                                       : 8'($urandom_range(MaxFrameLenDef + 1, 255)));
      repeat ($urandom_range(0, 3)) send(ACT_PUSH, 8'($urandom_range(255)));
    end else if (pick < 77) begin
      push_frame(flen, 1'b1);
    end else if (pick < 87) begin
      push_frame(flen, 1'b0, $urandom_range(1, flen + 1));
      pop();
    end else begin
      pop();
    end
  endtask

  // overfill with max-length frames, then pop against a held-off output
  task automatic flood();
    repeat (4) push_frame(MaxFrameLenDef, 1'b0);
    hold_seq <= hold_seq + 1;
    repeat (6) pop();
    drain();
  endtask

  initial begin
    logic [7:0] sync_set [4];
    logic [7:0] poly_set [4];
    int         target;
    sync_set = '{SyncByteRst, 8'h00, 8'hFF, 8'($urandom_range(255))};
    poly_set = '{CrcPolyRst, 8'hFF, 8'h00, 8'($urandom_range(255))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain();
        repeat (SettleCycles) @(posedge clk_i);
      end
      set_config(sync_set[phase], poly_set[phase]);
      if (phase == 0) directed();
      if (phase == 1) flood();
      quiet  <= (phase == 2);
      target = items_sent + PhaseItems;
      while (items_sent < target) random_burst();
    end
    drain();
    quiet <= 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sfdcrc8_pkg.sv
src/sfdcrc8_dp.sv
src/sfdcrc8_ctrl.sv
src/sync_frame_deframer_crc8.sv
src/sfdcrc8_checker.sv
tb/sv/sfd_tb_pkg.sv
tb/sv/sfd_frame_checker.sv
tb/sv/tb_sync_frame_deframer_crc8.sv
